### design/assert_macros.svh
// Shared assertion macros for the design checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Invariant.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant check failed");

`endif

### design/brce_pkg.sv
package brce_pkg;

  // Memory geometry
  localparam int WORD_BITS  = 32;
  localparam int MEM_WORDS  = 1024;
  localparam int ADDR_W     = $clog2(MEM_WORDS);
  localparam int LANE_W     = $clog2(WORD_BITS);
  localparam int TOTAL_BITS = MEM_WORDS * WORD_BITS;
  // bit positions, wide enough to hold TOTAL_BITS itself
  localparam int POS_W      = $clog2(TOTAL_BITS) + 1;

  // Item field widths
  localparam int REQ_W      = 2;
  localparam int WADDR_W    = 10;
  localparam int BIT_W      = 15;
  localparam int CNT_W      = 16;
  localparam int STATUS_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE,
    REQ_READ,
    REQ_COPY
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_RANGE,
    ST_OVERLAP
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RDRET,
    S_RA,
    S_RB,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } ram_req_t;

endpackage

### design/brce_ram.sv
module brce_ram
  import brce_pkg::*;
(
  input  logic                 clk,
  input  ram_req_t             req,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end

endmodule

### design/bit_range_copy_engine.sv
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------------
// request  | req_valid | req_stall | req_type word_addr write_data src_bit dst_bit bit_count
// response | rsp_valid | rsp_stall | read_data status
//
// Each item passes the check and done states; a read adds a read-return state, and
// a legal copy loops per destination word, at most 16384 bits between the two halves.
// Each destination word costs two source reads, a destination read and a write-back.
// Reset clears the sequencer and the response valid; memory stays undefined until
// written, with no clearing pass.
// A stalled response holds; a new item is taken while it waits.
module bit_range_copy_engine
  import brce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [WADDR_W-1:0]   word_addr,
  input  logic [WORD_BITS-1:0] write_data,
  input  logic [BIT_W-1:0]     src_bit,
  input  logic [BIT_W-1:0]     dst_bit,
  input  logic [CNT_W-1:0]     bit_count,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [WORD_BITS-1:0] read_data,
  output logic [STATUS_W-1:0]  status
);

  state_t state, state_next;

  // captured request
  logic [REQ_W-1:0]     req_q, req_q_next;
  logic [WADDR_W-1:0]   addr_q, addr_q_next;
  logic [WORD_BITS-1:0] wdata_q, wdata_q_next;
  logic [BIT_W-1:0]     src_q, src_q_next;
  logic [BIT_W-1:0]     dst_q, dst_q_next;
  logic [CNT_W-1:0]     cnt_q, cnt_q_next;

  // copy walk: current destination bit, end of run, current source bit
  logic [POS_W-1:0]     cur, cur_next;
  logic [POS_W-1:0]     end_q, end_q_next;
  logic [POS_W-1:0]     src_cur, src_cur_next;
  // the two source words that cover the current chunk
  logic [WORD_BITS-1:0] a_word, a_word_next;
  logic [WORD_BITS-1:0] b_word, b_word_next;

  // pending result
  logic [WORD_BITS-1:0] res_data, res_data_next;
  status_t              res_status, res_status_next;

  logic                 rsp_valid_next;
  logic [WORD_BITS-1:0] read_data_next;
  logic [STATUS_W-1:0]  status_next;

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rd;

  brce_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  // range and overlap checks, all in POS_W+1 bits so sums never wrap
  logic [POS_W:0] src_end, dst_end, src_ext, dst_ext;
  logic           out_of_range, overlap;

  assign src_ext      = (POS_W+1)'(src_q);
  assign dst_ext      = (POS_W+1)'(dst_q);
  assign src_end      = src_ext + (POS_W+1)'(cnt_q);
  assign dst_end      = dst_ext + (POS_W+1)'(cnt_q);
  assign out_of_range = (src_end > (POS_W+1)'(TOTAL_BITS)) ||
                        (dst_end > (POS_W+1)'(TOTAL_BITS));
  assign overlap      = (src_ext < dst_end) && (dst_ext < src_end);

  // chunk of the run that lands in the current destination word
  logic [LANE_W-1:0]      lo;
  logic [LANE_W:0]        room, take, lim;
  logic [POS_W-1:0]       rem;
  logic [WORD_BITS-1:0]   mask, aligned, placed, merged;
  logic [2*WORD_BITS-1:0] window;
  logic [ADDR_W-1:0]      src_word, dst_word;

  assign lo       = cur[LANE_W-1:0];
  assign room     = (LANE_W+1)'(WORD_BITS) - (LANE_W+1)'(lo);
  assign rem      = end_q - cur;
  assign take     = (rem < POS_W'(room)) ? rem[LANE_W:0] : room;
  assign lim      = (LANE_W+1)'(lo) + take;
  assign mask     = ({WORD_BITS{1'b1}} >> lo) & ~({WORD_BITS{1'b1}} >> lim);
  // first source bit of the chunk moves to the MSB, then over to lo
  assign window   = {a_word, b_word} << src_cur[LANE_W-1:0];
  assign aligned  = window[2*WORD_BITS-1:WORD_BITS];
  assign placed   = aligned >> lo;
  assign merged   = (ram_rd & ~mask) | (placed & mask);
  assign src_word = src_cur[LANE_W +: ADDR_W];
  assign dst_word = cur[LANE_W +: ADDR_W];

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    addr_q     <= addr_q_next;
    wdata_q    <= wdata_q_next;
    src_q      <= src_q_next;
    dst_q      <= dst_q_next;
    cnt_q      <= cnt_q_next;
    cur        <= cur_next;
    end_q      <= end_q_next;
    src_cur    <= src_cur_next;
    a_word     <= a_word_next;
    b_word     <= b_word_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    read_data  <= read_data_next;
    status     <= status_next;
  end

  always_comb begin
    state_next      = state;
    req_q_next      = req_q;
    addr_q_next     = addr_q;
    wdata_q_next    = wdata_q;
    src_q_next      = src_q;
    dst_q_next      = dst_q;
    cnt_q_next      = cnt_q;
    cur_next        = cur;
    end_q_next      = end_q;
    src_cur_next    = src_cur;
    a_word_next     = a_word;
    b_word_next     = b_word;
    res_data_next   = res_data;
    res_status_next = res_status;
    read_data_next  = read_data;
    status_next     = status;
    rsp_valid_next  = rsp_valid && rsp_stall;
    ram_req         = '{we: 1'b0, addr: dst_word, wdata: merged};

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_q_next   = req_type;
          addr_q_next  = word_addr;
          wdata_q_next = write_data;
          src_q_next   = src_bit;
          dst_q_next   = dst_bit;
          cnt_q_next   = bit_count;
          state_next   = S_CHECK;
        end
      end

      S_CHECK: begin
        res_data_next   = '0;
        res_status_next = ST_OK;
        state_next      = S_DONE;
        case (req_q)
          REQ_WRITE: begin
            if ((ADDR_W+1)'(addr_q) < (ADDR_W+1)'(MEM_WORDS)) begin
              ram_req = '{we: 1'b1, addr: ADDR_W'(addr_q), wdata: wdata_q};
            end else begin
              res_status_next = ST_RANGE;
            end
          end
          REQ_READ: begin
            if ((ADDR_W+1)'(addr_q) < (ADDR_W+1)'(MEM_WORDS)) begin
              ram_req.addr = ADDR_W'(addr_q);
              state_next   = S_RDRET;
            end else begin
              res_status_next = ST_RANGE;
            end
          end
          REQ_COPY: begin
            if (out_of_range) begin
              res_status_next = ST_RANGE;
            end else if (cnt_q == '0) begin
              res_status_next = ST_OK;
            end else if (overlap) begin
              res_status_next = ST_OVERLAP;
            end else begin
              cur_next     = POS_W'(dst_q);
              src_cur_next = POS_W'(src_q);
              end_q_next   = POS_W'(dst_end);
              state_next   = S_RA;
            end
          end
          default: begin
            // unused request code: plain ok, nothing touched
          end
        endcase
      end

      S_RDRET: begin
        res_data_next = ram_rd;
        state_next    = S_DONE;
      end

      S_RA: begin
        ram_req.addr = src_word;
        state_next   = S_RB;
      end

      S_RB: begin
        // next source word; past the end it wraps and its bits get masked off
        ram_req.addr = ADDR_W'(src_word + 1'b1);
        a_word_next  = ram_rd;
        state_next   = S_RD;
      end

      S_RD: begin
        ram_req.addr = dst_word;
        b_word_next  = ram_rd;
        state_next   = S_WR;
      end

      S_WR: begin
        ram_req      = '{we: 1'b1, addr: dst_word, wdata: merged};
        cur_next     = cur + POS_W'(take);
        src_cur_next = src_cur + POS_W'(take);
        state_next   = (cur_next == end_q) ? S_DONE : S_RA;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          read_data_next = res_data;
          status_next    = res_status;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/brce_checker.sv
`include "assert_macros.svh"

module brce_sva
  import brce_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input logic [WORD_BITS-1:0] read_data,
  input logic [STATUS_W-1:0]  status
);

  // items taken but not yet answered
  logic [1:0] pending;
  logic       req_take, rsp_take;

  assign req_take = req_valid && !req_stall;
  assign rsp_take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_take) - 2'(rsp_take);
    end
  end

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
               rsp_valid && $stable(read_data) && $stable(status))
  `ASSERT_ALWAYS(a_pending_max, clk, rst, pending <= 2'd2)
  `ASSERT_IMPL(a_no_orphan, clk, rst, rsp_valid, pending != 2'd0)
  `ASSERT_IMPL(a_err_zero, clk, rst, rsp_valid && status != ST_OK, read_data == '0)

endmodule

bind bit_range_copy_engine brce_sva u_brce_sva (.*);

### bench/brce_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each response from its own copy of the word
// memory and compares in order.
module brce_checker
  import brce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [WADDR_W-1:0]   word_addr,
  input  logic [WORD_BITS-1:0] write_data,
  input  logic [BIT_W-1:0]     src_bit,
  input  logic [BIT_W-1:0]     dst_bit,
  input  logic [CNT_W-1:0]     bit_count,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic [WORD_BITS-1:0] read_data,
  input  logic [STATUS_W-1:0]  status,
  output int                   errors,
  output int                   pending
);

  typedef struct {
    logic [WORD_BITS-1:0] read_data;
    status_t              status;
  } rsp_t;

  logic [WORD_BITS-1:0] store_model [MEM_WORDS];
  rsp_t                 awaited_rsp_q [$];

  // bit b lives in word b/WORD_BITS, MSB first
  function automatic status_t copy_bits(int unsigned src, int unsigned dst, int unsigned cnt);
    int unsigned b;
    if (src + cnt > TOTAL_BITS || dst + cnt > TOTAL_BITS) return ST_RANGE;
    if (cnt == 0) return ST_OK;
    if (src < dst + cnt && dst < src + cnt) return ST_OVERLAP;
    for (b = 0; b < cnt; b++) begin
      store_model[(dst + b) / WORD_BITS][WORD_BITS - 1 - (dst + b) % WORD_BITS] =
        store_model[(src + b) / WORD_BITS][WORD_BITS - 1 - (src + b) % WORD_BITS];
    end
    return ST_OK;
  endfunction

  function automatic rsp_t apply_request(req_t kind, int unsigned addr,
                                         logic [WORD_BITS-1:0] wdata, int unsigned src,
                                         int unsigned dst, int unsigned cnt);
    rsp_t r;
    r.read_data = '0;
    r.status    = ST_OK;
    case (kind)
      REQ_WRITE: begin
        if (addr < MEM_WORDS) store_model[addr] = wdata;
        else r.status = ST_RANGE;
      end
      REQ_READ: begin
        if (addr < MEM_WORDS) r.read_data = store_model[addr];
        else r.status = ST_RANGE;
      end
      REQ_COPY: r.status = copy_bits(src, dst, cnt);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   bad;
    bad = 0;
    if (rst) begin
      awaited_rsp_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp_q.size() == 0) begin
          $display("%0t: response with none awaited: read_data %h status %0d",
                   $time, read_data, status);
          bad++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
            bad++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            bad++;
          end
        end
      end
      if (req_valid && !req_stall)
        awaited_rsp_q.push_back(apply_request(req_t'(req_type), 32'(word_addr), write_data,
                                              32'(src_bit), 32'(dst_bit), 32'(bit_count)));
      errors  <= errors + bad;
      pending <= awaited_rsp_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Bench for the bit range copy engine.
// The top drives requests and the response stall; brce_checker does all the
// prediction and comparison and hands back a mismatch count.
// Memory is undefined until written, so the top keeps a per-word map of words
// whose every bit is known and only reads such words or copies out of them.
module tb;
  import brce_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;  // ignored request code
  localparam int unsigned      RANDOM_ITEMS = 880;
  localparam int unsigned      HOLD_CYCLES  = 300;   // long response hold-off

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [REQ_W-1:0]     req_type;
  logic [WADDR_W-1:0]   word_addr;
  logic [WORD_BITS-1:0] write_data;
  logic [BIT_W-1:0]     src_bit;
  logic [BIT_W-1:0]     dst_bit;
  logic [CNT_W-1:0]     bit_count;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [WORD_BITS-1:0] read_data;
  logic [STATUS_W-1:0]  status;

  int errors;
  int pending;

  // word_ok[w]: all bits of word w hold known values
  bit          word_ok [MEM_WORDS];
  bit          req_gaps;      // sender idles between items
  bit          rsp_gaps;      // receiver stalls between items
  bit          hold_request;  // ask the receiver for one long hold-off
  int unsigned last_waddr;

  int unsigned n_write, n_read, n_copy, n_range, n_overlap, n_ignored;
  longint unsigned bits_moved;

  bit_range_copy_engine DUT (.*);
  brce_checker          checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a back-to-back item never lowers and raises it.
  task automatic send_item(logic [REQ_W-1:0] kind, int unsigned addr,
                           logic [WORD_BITS-1:0] data, int unsigned s,
                           int unsigned d, int unsigned n);
    int unsigned gap;
    gap = req_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    word_addr  <= WADDR_W'(addr);
    write_data <= data;
    src_bit    <= BIT_W'(s);
    dst_bit    <= BIT_W'(d);
    bit_count  <= CNT_W'(n);
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic issue_write(int unsigned addr, logic [WORD_BITS-1:0] data);
    send_item(REQ_WRITE, addr, data, $urandom, $urandom, $urandom);
    word_ok[addr] = 1'b1;
    last_waddr    = addr;
    n_write++;
  endtask

  task automatic issue_read(int unsigned addr);
    send_item(REQ_READ, addr, $urandom, $urandom, $urandom, $urandom);
    n_read++;
  endtask

  // Tracks which destination words become fully known after a legal copy.
  // Partly covered words keep their old state.
  task automatic issue_copy(int unsigned s, int unsigned d, int unsigned n);
    int unsigned w;
    send_item(REQ_COPY, $urandom, $urandom, s, d, n);
    if (s + n > TOTAL_BITS || d + n > TOTAL_BITS) begin
      n_range++;
    end else if (n != 0 && s < d + n && d < s + n) begin
      n_overlap++;
    end else begin
      n_copy++;
      bits_moved += n;
      for (w = (d + WORD_BITS - 1) / WORD_BITS; (w + 1) * WORD_BITS <= d + n; w++)
        word_ok[w] = 1'b1;
    end
  endtask

  task automatic random_write();
    int unsigned a;
    // half the writes extend the last one so long known runs build up
    a = $urandom_range(0, 1) ? (last_waddr + 1) % MEM_WORDS : $urandom_range(0, MEM_WORDS - 1);
    issue_write(a, $urandom);
  endtask

  // Drop valid and wait until every awaited response is back.
  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Response side: a drawn stall per item, or one long hold when asked.
  initial begin
    int unsigned stall_cycles;
    rsp_stall = 1'b0;
    forever begin
      stall_cycles = rsp_gaps ? $urandom_range(0, 4) : 0;
      if (hold_request) begin
        stall_cycles = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned pick, want, s, d, n, w, last, tries;
    bit          found;

    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_WRITE;
    word_addr  = '0;
    write_data = '0;
    src_bit    = '0;
    dst_bit    = '0;
    bit_count  = '0;
    req_gaps   = 1'b1;
    rsp_gaps   = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    issue_write(0, 32'hFFFF_FFFF);
    issue_write(1, 32'h8000_0001);
    issue_write(2, 32'h0000_0000);
    issue_write(1023, 32'hA5A5_A5A5);
    issue_write(1022, 32'h5A5A_5A5A);
    issue_write(512, 32'h1234_5678);
    issue_read(0);
    issue_read(1023);
    issue_copy(0, 100, 1);                        // single bit
    issue_copy(1, 3 * WORD_BITS, 63);             // odd source offset, aligned target
    issue_copy(WORD_BITS, 5 * WORD_BITS, 64);     // word aligned both sides
    issue_copy(TOTAL_BITS - 57, 323, 57);         // source ends at memory end
    issue_copy(0, TOTAL_BITS - 40, 40);           // target ends at memory end
    issue_copy(TOTAL_BITS - 1, TOTAL_BITS - 1, 0); // zero length at the top bit
    issue_copy(0, 0, 0);                          // zero length, same offsets
    issue_copy(TOTAL_BITS - 1, 0, 2);             // source past the end
    issue_copy(0, TOTAL_BITS - 1, 2);             // target past the end
    issue_copy(1, 0, TOTAL_BITS);                 // full count, shifted: past the end
    issue_copy(5, 5, 1);                          // same offset overlaps
    issue_copy(0, 0, TOTAL_BITS);                 // whole memory onto itself
    issue_copy(10, 20, 11);                       // share exactly one bit
    issue_copy(10, 20, 10);                       // touching runs are legal
    send_item(REQ_UNUSED, '1, '1, '1, '1, '1);
    n_ignored++;
    issue_read(3);
    issue_read(1022);
    drain();

    // ---- random part, four flow-control phases ----
    for (int ph = 0; ph < 4; ph++) begin
      req_gaps = (ph == 0) || (ph == 2);
      rsp_gaps = (ph == 0) || (ph == 3);
      // phase 1: sender runs flat out into a long response hold so the block fills
      if (ph == 1) hold_request = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          random_write();
        end else if (pick < 50) begin
          found = 1'b0;
          for (tries = 0; tries < 16 && !found; tries++) begin
            w     = $urandom_range(0, MEM_WORDS - 1);
            found = word_ok[w];
          end
          if (found) issue_read(w);
          else random_write();
        end else if (pick < 88) begin
          // legal copy: source must lie in known words
          pick = $urandom_range(0, 99);
          if (pick < 70) want = $urandom_range(1, 64);
          else if (pick < 95) want = $urandom_range(65, 512);
          else want = $urandom_range(513, 4096);
          found = 1'b0;
          for (tries = 0; tries < 16 && !found; tries++) begin
            w     = $urandom_range(0, MEM_WORDS - 1);
            found = word_ok[w];
          end
          if (!found) begin
            random_write();
          end else begin
            s = w * WORD_BITS;
            if ($urandom_range(0, 3) != 0) s += $urandom_range(0, WORD_BITS - 1);
            last = w;
            while (last + 1 < MEM_WORDS && word_ok[last + 1] &&
                   (last + 1 - w) * WORD_BITS < want + WORD_BITS)
              last++;
            n = (last + 1) * WORD_BITS - s;
            if (n > want) n = want;
            found = 1'b0;
            for (tries = 0; tries < 16 && !found; tries++) begin
              d = $urandom_range(0, TOTAL_BITS - n);
              if ($urandom_range(0, 4) == 0) d -= d % WORD_BITS;
              if ($urandom_range(0, 15) == 0) d = TOTAL_BITS - n;
              found = !(s < d + n && d < s + n);
            end
            if (found) issue_copy(s, d, n);
            else random_write();
          end
        end else if (pick < 93) begin
          // past the end on at least one side
          s = $urandom_range(1, TOTAL_BITS - 1);
          n = $urandom_range(TOTAL_BITS - s + 1, TOTAL_BITS);
          d = $urandom_range(0, TOTAL_BITS - 1);
          if ($urandom_range(0, 1)) issue_copy(d, s, n);
          else issue_copy(s, d, n);
        end else if (pick < 97) begin
          // overlapping runs, either direction
          n = $urandom_range(1, 64);
          s = $urandom_range(0, TOTAL_BITS - 2 * n);
          d = s + $urandom_range(0, n - 1);
          if ($urandom_range(0, 1)) issue_copy(d, s, n);
          else issue_copy(s, d, n);
        end else if (pick < 99) begin
          issue_copy($urandom_range(0, TOTAL_BITS - 1), $urandom_range(0, TOTAL_BITS - 1), 0);
        end else begin
          send_item(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
          n_ignored++;
        end
      end
      // sender pause until everything is back
      drain();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d writes, %0d reads and %0d items of the unused type",
             n_write, n_read, n_ignored);
    $display("Copies: %0d legal moving %0d bits, %0d past the end, %0d overlapping",
             n_copy, bits_moved, n_range, n_overlap);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
